// ===== src/rwcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rwcr_pkg
// Shared types, constants and the read command table of the command router.
// ----------------------------------------------------------------------------
package rwcr_pkg;

    localparam int NAME_W      = 8;
    localparam int DRAW_W      = 31;
    localparam int WEIGHT_W    = 16;
    localparam int TOTAL_W     = 18;
    localparam int TABLE_CHARS = 16;
    localparam int READ_NAMES  = 38;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [2:0] PH_FIRST = 3'd0;
    localparam logic [2:0] PH_SLASH = 3'd1;
    localparam logic [2:0] PH_NAME  = 3'd2;
    localparam logic [2:0] PH_KEY   = 3'd3;
    localparam logic [2:0] PH_TAIL  = 3'd4;

    localparam logic [1:0] FR_NONE    = 2'd0;
    localparam logic [1:0] FR_MASTER  = 2'd1;
    localparam logic [1:0] FR_REPLICA = 2'd2;
    localparam logic [1:0] FR_BAD     = 2'd3;

    typedef logic [TABLE_CHARS*8-1:0] t_name;

    // controller to datapath
    typedef struct packed {
        logic start;     // load draw and total, begin reduction
        logic step;      // one restoring-division step
        logic pick;      // register slot selection
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_status;

    typedef struct packed {
        logic       to_master;
        logic [1:0] replica_slot;
        logic       read_command;
        logic       no_replica_fallback;
        logic       bad_prefix;
    } t_route;

    function automatic t_name name_const(input int idx);
        case (idx)
            0:  name_const = t_name'("DUMP");
            1:  name_const = t_name'("EXISTS");
            2:  name_const = t_name'("GET");
            3:  name_const = t_name'("GETBIT");
            4:  name_const = t_name'("GETRANGE");
            5:  name_const = t_name'("HEXISTS");
            6:  name_const = t_name'("HGET");
            7:  name_const = t_name'("HGETALL");
            8:  name_const = t_name'("HKEYS");
            9:  name_const = t_name'("HLEN");
            10: name_const = t_name'("HMGET");
            11: name_const = t_name'("HVALS");
            12: name_const = t_name'("LLEN");
            13: name_const = t_name'("LRANGE");
            14: name_const = t_name'("MGET");
            15: name_const = t_name'("PTTL");
            16: name_const = t_name'("SCARD");
            17: name_const = t_name'("SDIFF");
            18: name_const = t_name'("SINTER");
            19: name_const = t_name'("SMEMBERS");
            20: name_const = t_name'("SRANDMEMBER");
            21: name_const = t_name'("STRLEN");
            22: name_const = t_name'("TTL");
            23: name_const = t_name'("TYPE");
            24: name_const = t_name'("ZCARD");
            25: name_const = t_name'("ZCOUNT");
            26: name_const = t_name'("ZLEXCOUNT");
            27: name_const = t_name'("ZRANGE");
            28: name_const = t_name'("ZRANGEBYLEX");
            29: name_const = t_name'("ZRANGEBYSCORE");
            30: name_const = t_name'("ZRANK");
            31: name_const = t_name'("ZREVRANGE");
            32: name_const = t_name'("ZREVRANGEBYSCORE");
            33: name_const = t_name'("ZREVRANK");
            34: name_const = t_name'("ZSCORE");
            35: name_const = t_name'("SSCAN");
            36: name_const = t_name'("HSCAN");
            37: name_const = t_name'("ZSCAN");
            default: name_const = '0;
        endcase
    endfunction

    function automatic logic [4:0] name_len(input int idx);
        t_name      s;
        logic [4:0] n;
        s = name_const(idx);
        n = '0;
        for (int k = 0; k < TABLE_CHARS; k++) begin
            if (s[k*8 +: 8] != 8'h00) begin
                n = n + 5'd1;
            end
        end
        name_len = n;
    endfunction

    // string literal is right-aligned; char j of the name at byte (len-1-j)
    function automatic logic [7:0] name_char(input int idx, input int j);
        t_name s;
        int    l;
        s = name_const(idx);
        l = int'(name_len(idx));
        if (j < l) begin
            name_char = s[(l-1-j)*8 +: 8];
        end else begin
            name_char = 8'h00;
        end
    endfunction

endpackage

// ===== src/rwcr_parser.sv =====
// ----------------------------------------------------------------------------
// rwcr_parser
// Byte-serial command parser: prefix, uppercased name store and key scan.
// ----------------------------------------------------------------------------
module rwcr_parser #(
    parameter int MAX_NAME_CHARS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_last,
    input  logic [7:0] i_byte,
    output logic       o_is_read,
    output logic       o_bad
);
    import rwcr_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME_CHARS + 1);
    localparam int IDX_W = $clog2(MAX_NAME_CHARS);

    logic [2:0]       r_phase, n_phase;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_long, n_long;
    logic             r_key, n_key;
    logic [1:0]       r_force, n_force;
    logic [7:0]       r_name [MAX_NAME_CHARS];
    logic             name_wr;
    logic [7:0]       up_byte;
    logic [1:0]       final_force;
    logic             match;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_long  = r_long;
        n_key   = r_key;
        n_force = r_force;
        name_wr = 1'b0;
        up_byte = i_byte;
        if (i_byte >= 8'h61 && i_byte <= 8'h7A) begin
            up_byte = i_byte - 8'h20;
        end
        case (r_phase)
            PH_FIRST, PH_NAME: begin
                if (r_phase == PH_FIRST && i_byte == CH_SLASH) begin
                    n_phase = PH_SLASH;
                end else if (i_byte == CH_NUL) begin
                    n_phase = PH_TAIL;
                end else if (i_byte == CH_SPACE) begin
                    n_phase = PH_KEY;
                end else if (r_len < LEN_W'(MAX_NAME_CHARS)) begin
                    n_phase = PH_NAME;
                    name_wr = 1'b1;
                    n_len   = r_len + LEN_W'(1);
                end else begin
                    n_phase = PH_NAME;
                    n_long  = 1'b1;
                end
            end
            PH_SLASH: begin
                if (i_byte == CH_W) begin
                    n_force = FR_MASTER;
                end else if (i_byte == CH_R) begin
                    n_force = FR_REPLICA;
                end else begin
                    n_force = FR_BAD;
                end
                n_phase = PH_TAIL;
            end
            PH_KEY: begin
                if (i_byte == CH_NUL || i_byte == CH_SPACE) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_key = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // table compare on the stored name plus the byte taken this cycle
    always_comb begin
        logic [7:0] c;
        logic       hit;
        match = 1'b0;
        for (int t = 0; t < READ_NAMES; t++) begin
            hit = (n_len == LEN_W'(name_len(t))) && !n_long;
            for (int j = 0; j < MAX_NAME_CHARS && j < TABLE_CHARS; j++) begin
                c = (name_wr && r_len == LEN_W'(j)) ? up_byte : r_name[j];
                if (LEN_W'(j) < n_len && c != name_char(t, j)) begin
                    hit = 1'b0;
                end
            end
            if (n_len == '0) begin
                hit = 1'b0;
            end
            match = match | hit;
        end
    end

    always_comb begin
        final_force = n_force;
        if (n_phase == PH_SLASH) begin
            final_force = FR_BAD;
        end
        o_bad = final_force == FR_BAD;
        case (final_force)
            FR_REPLICA: o_is_read = 1'b1;
            FR_NONE:    o_is_read = n_key && match;
            default:    o_is_read = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_len   <= '0;
            r_long  <= 1'b0;
            r_key   <= 1'b0;
            r_force <= FR_NONE;
        end else if (i_take) begin
            if (i_last) begin
                r_phase <= PH_FIRST;
                r_len   <= '0;
                r_long  <= 1'b0;
                r_key   <= 1'b0;
                r_force <= FR_NONE;
            end else begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_long  <= n_long;
                r_key   <= n_key;
                r_force <= n_force;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && name_wr) begin
            r_name[r_len[IDX_W-1:0]] <= up_byte;
        end
    end

endmodule

// ===== src/rwcr_datapath.sv =====
// ----------------------------------------------------------------------------
// rwcr_datapath
// Weight total, draw modulo total by restoring division, slot selection.
// ----------------------------------------------------------------------------
module rwcr_datapath #(
    parameter int REPLICA_SLOTS = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rwcr_pkg::t_cmd              i_cmd,
    input  logic [rwcr_pkg::DRAW_W-1:0] i_draw,
    input  logic [15:0]                 i_w0,
    input  logic [15:0]                 i_w1,
    input  logic [15:0]                 i_w2,
    input  logic [15:0]                 i_w3,
    output rwcr_pkg::t_status           o_status,
    output logic [1:0]                  o_slot,
    output logic                        o_total_zero
);
    import rwcr_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W + 1);

    logic [WEIGHT_W-1:0] w [4];
    logic [TOTAL_W-1:0]  r_total;
    logic [DRAW_W-1:0]   r_quot;
    logic [TOTAL_W:0]    r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [1:0]          r_slot;
    logic [TOTAL_W-1:0]  sum_all;
    logic [TOTAL_W:0]    shifted;
    logic [TOTAL_W-1:0]  run;
    logic [1:0]          pick;
    logic                found;

    always_comb begin
        w[0] = i_w0;
        w[1] = (REPLICA_SLOTS > 1) ? i_w1 : '0;
        w[2] = (REPLICA_SLOTS > 2) ? i_w2 : '0;
        w[3] = (REPLICA_SLOTS > 3) ? i_w3 : '0;
        sum_all = TOTAL_W'(w[0]) + TOTAL_W'(w[1]) + TOTAL_W'(w[2]) + TOTAL_W'(w[3]);
        shifted = {r_rem[TOTAL_W-1:0], r_quot[DRAW_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= CNT_W'(DRAW_W);
        end else if (i_cmd.step && r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_total <= sum_all;
            r_quot  <= i_draw;
            r_rem   <= '0;
        end else if (i_cmd.step && r_cnt != '0) begin
            r_quot <= {r_quot[DRAW_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_total}) begin
                r_rem <= shifted - {1'b0, r_total};
            end else begin
                r_rem <= shifted;
            end
        end
    end

    always_comb begin
        run   = '0;
        pick  = '0;
        found = 1'b0;
        for (int i = 0; i < 4; i++) begin
            run = run + TOTAL_W'(w[i]);
            if (!found && w[i] != '0 && {1'b0, run} > r_rem) begin
                pick  = 2'(i);
                found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pick) begin
            r_slot <= pick;
        end
    end

    assign o_status.div_done = (r_cnt == '0);
    assign o_slot            = r_slot;
    assign o_total_zero      = (sum_all == '0);

endmodule

// ===== src/rwcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rwcr_ctrl
// Controller: accepts bytes, sequences the modulo, holds the result register.
// ----------------------------------------------------------------------------
module rwcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_last,
    input  logic              i_is_read,
    input  logic              i_bad,
    input  logic              i_total_zero,
    input  logic [1:0]        i_slot,
    output rwcr_pkg::t_cmd    o_cmd,
    input  rwcr_pkg::t_status i_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rwcr_pkg::t_route  o_route
);
    import rwcr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_valid;
    t_route     r_route;
    logic       take, take_last, out_take, wait_div;

    assign out_take    = r_valid && i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_valid || i_out_ready);
    assign take        = i_in_valid && o_in_ready;
    assign take_last   = take && i_last;
    assign wait_div    = i_is_read && !i_total_zero;
    assign o_out_valid = r_valid;
    assign o_route     = r_route;

    always_comb begin
        n_state     = r_state;
        o_cmd.start = 1'b0;
        o_cmd.step  = 1'b0;
        o_cmd.pick  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (take_last && wait_div) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.pick = 1'b1;
                    n_state    = ST_PICK;
                end
            end
            ST_PICK: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (take_last && !wait_div) begin
                r_valid <= 1'b1;
            end else if (r_state == ST_PICK) begin
                r_valid <= 1'b1;
            end else if (out_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_last) begin
            r_route.to_master           <= !wait_div;
            r_route.replica_slot        <= 2'd0;
            r_route.read_command        <= i_is_read;
            r_route.no_replica_fallback <= i_is_read && i_total_zero;
            r_route.bad_prefix          <= i_bad;
        end else if (r_state == ST_PICK) begin
            r_route.replica_slot <= i_slot;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_in_ready)
        else $error("byte taken while routing busy");
    a_pick_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PICK |=> o_out_valid && !r_route.to_master)
        else $error("replica result not presented");
    a_master_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_route.to_master |-> r_route.replica_slot == 2'd0)
        else $error("slot nonzero on master route");
    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_route.no_replica_fallback |-> r_route.to_master)
        else $error("fallback without master route");
`endif

endmodule

// ===== src/read_write_command_router_core.sv =====
// ----------------------------------------------------------------------------
// read_write_command_router_core
// Routes a byte-serial command to the master or a weighted replica slot.
//
// channel  dir  handshake              payload
// s_axis   in   tvalid/tready          tdata: text_byte[7:0], random_draw[38:8]
//                                      tlast: end_of_message
// m_axis   out  tvalid/tready          tdata: to_master, replica_slot, read_command,
//                                             no_replica_fallback, bad_prefix
// apb      in   psel/penable/pwrite    weights of slots 0..3 at 0x0,0x4,0x8,0xC
//
// One byte per cycle while input is not held off. A final byte of a read that
// picks a replica is followed by 31 restoring-division steps of draw by total
// weight; then the slot pick is registered and the result is loaded. Other
// final bytes load the result directly. Input waits during the division.
// A pending result in the output register holds off input until taken.
// Synchronous reset clears parser state, weights and the output valid flag.
// ----------------------------------------------------------------------------
module read_write_command_router_core #(
    parameter int REPLICA_SLOTS  = 4,
    parameter int MAX_NAME_CHARS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // text_byte[7:0], random_draw[38:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // to_master, replica_slot[2:1], read_command,
                                        // no_replica_fallback, bad_prefix
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rwcr_pkg::*;

    logic [15:0] r_w0, r_w1, r_w2, r_w3;
    t_cmd        cmd;
    t_status     status;
    t_route      route;
    logic        is_read, bad, total_zero, take;
    logic [1:0]  slot;

    assign pready = 1'b1;
    assign take   = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
            r_w2 <= '0;
            r_w3 <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                4'h0:    r_w0 <= pwdata[15:0];
                4'h4:    r_w1 <= pwdata[15:0];
                4'h8:    r_w2 <= pwdata[15:0];
                4'hC:    r_w3 <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr)
            4'h0:    prdata = {16'd0, r_w0};
            4'h4:    prdata = {16'd0, r_w1};
            4'h8:    prdata = {16'd0, r_w2};
            4'hC:    prdata = {16'd0, r_w3};
            default: prdata = '0;
        endcase
    end

    rwcr_parser #(.MAX_NAME_CHARS(MAX_NAME_CHARS)) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_last    (s_axis_tlast),
        .i_byte    (s_axis_tdata[7:0]),
        .o_is_read (is_read),
        .o_bad     (bad)
    );

    rwcr_datapath #(.REPLICA_SLOTS(REPLICA_SLOTS)) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_draw       (s_axis_tdata[38:8]),
        .i_w0         (r_w0),
        .i_w1         (r_w1),
        .i_w2         (r_w2),
        .i_w3         (r_w3),
        .o_status     (status),
        .o_slot       (slot),
        .o_total_zero (total_zero)
    );

    rwcr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_last       (s_axis_tlast),
        .i_is_read    (is_read),
        .i_bad        (bad),
        .i_total_zero (total_zero),
        .i_slot       (slot),
        .o_cmd        (cmd),
        .i_status     (status),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_route      (route)
    );

    assign m_axis_tdata = {2'b00, route.bad_prefix, route.no_replica_fallback,
                           route.read_command, route.replica_slot, route.to_master};

endmodule
